// File: hdl/tsta_pkg.sv
package tsta_pkg;

    localparam int SLOTS = 62;

    localparam logic [7:0] CH_MARK  = 8'h7C;
    localparam logic [7:0] CH_SHIFT = 8'h7D;
    localparam logic [7:0] CH_DOWN  = 8'h7E;

    localparam logic [30:0] MAX_SESSION_RESET = 31'd129600;

    localparam logic [3:0] ST_IGNORED = 4'd0;
    localparam logic [3:0] ST_BADNAME = 4'd1;
    localparam logic [3:0] ST_MARK    = 4'd2;
    localparam logic [3:0] ST_SHIFT   = 4'd3;
    localparam logic [3:0] ST_DOWN    = 4'd4;
    localparam logic [3:0] ST_APPLIED = 4'd5;
    localparam logic [3:0] ST_FULL    = 4'd6;
    localparam logic [3:0] ST_READ    = 4'd7;
    localparam logic [3:0] ST_TTYZERO = 4'd8;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tty_code;
        logic [63:0] name_bytes;
        logic [30:0] stamp;
        logic        fill_nonzero;
        logic [5:0]  entry_index;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  status;
        logic [5:0]  credited_entry;
        logic [30:0] credited_seconds;
        logic [63:0] entry_name;
        logic [31:0] entry_seconds;
        logic        entry_used;
    } t_out_beat;

    // Name filter result: cleaned name or bad.
    typedef struct packed {
        logic        bad;
        logic [63:0] name;
    } t_name_chk;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic t_name_chk check_name(input logic [63:0] raw);
        t_name_chk r;
        logic      ended;
        logic [7:0] c;
        r.bad  = 1'b0;
        r.name = '0;
        ended  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            c = raw[8*i +: 8];
            if (is_alnum(c)) begin
                if (ended) r.bad = 1'b1;
                else r.name[8*i +: 8] = c;
            end else if (c == 8'h20 || c == 8'h00) begin
                ended = 1'b1;
            end else begin
                r.bad = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] map_slot(input logic [7:0] c);
        logic signed [9:0] i;
        if (c[7]) return 6'(SLOTS - 1);
        i = signed'({2'b00, c});
        if (c >= 8'h41 && c <= 8'h5A) i = i + 10'sd58;
        if (i >= 10'sd97) i = i - 10'sd39;
        i = i - 10'sd48;
        if (i < 0 || i >= 10'sd62) i = 10'sd61;
        return i[5:0];
    endfunction

endpackage

// File: hdl/tsta_close.sv
// Session close arithmetic: elapsed time, window test, saturating add.
module tsta_close (
    input  logic [30:0] i_stamp,
    input  logic [31:0] i_start,
    input  logic [30:0] i_max,
    input  logic [31:0] i_total,
    output logic        o_credit,
    output logic [30:0] o_elapsed,
    output logic [31:0] o_new_total
);
    logic signed [33:0] w_el;
    logic [32:0]        w_sum;

    assign w_el = signed'({3'b000, i_stamp}) - signed'({{2{i_start[31]}}, i_start});
    assign o_credit = (w_el > 34'sd0) && (w_el < signed'({3'b000, i_max}));
    assign o_elapsed = w_el[30:0];
    assign w_sum = {1'b0, i_total} + {2'b00, w_el[30:0]};
    assign o_new_total = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
endmodule

// File: hdl/terminal_session_time_accounting_unit.sv
// Terminal session time accounting unit.
// Input: a beat is taken when start is high and busy is low. Kind 0 is a
// login record, kind 1 reads one user entry.
// Config: i_cfg_we writes max_session_seconds from i_cfg_data; write only while
// idle. Reset value 129600.
// Output: one result per beat, shown for one cycle with o_done high. The
// receiver cannot stall; nothing is held.
// Steps: a mark, a shift without mark, an ignored or rejected record go from
// decode to finish. A read fetches the entry, then shows it. A single-terminal
// record reads its slot, then the user total, closes the slot, then, if a name
// is given, searches the user entries, fetching and matching one at a time.
// A clock shift with a mark walks all 62 slots, reading and shifting each.
// A shutdown walks all 62 slots, reading the slot and the total, then closing each.
// The slot walk and the user search share one read port per table and one close
// unit, and every table read is registered. busy drops in the o_done cycle, so
// the next beat may be taken at the edge that ends it.
// Reset: all slots unattached, all users empty, clock mark zero. The user
// table has a valid bit per entry so it reads empty at once; slot tables are
// not cleared, since a slot is written before it is ever attached.
module terminal_session_time_accounting_unit #(
    parameter int USERS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tsta_pkg::t_in_beat i_beat,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    output logic               o_done,
    output tsta_pkg::t_out_beat o_beat
);
    import tsta_pkg::*;

    localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RDOUT, S_SLOT_RD, S_TOT_RD, S_ACT, S_SEARCH, S_MATCH,
        S_FINISH
    } t_state;

    t_state      r_state;
    t_in_beat    r_in;
    t_name_chk   r_nm;
    logic [30:0] r_max;
    logic [31:0] r_mark;
    logic [5:0]  r_slot;
    logic [UW:0] r_uidx;
    t_out_beat   r_out;
    logic        r_done;

    logic [UW-1:0] r_slot_user  [SLOTS];
    logic [31:0]   r_slot_start [SLOTS];
    logic [SLOTS-1:0] r_att;
    logic [63:0]   r_uname  [USERS];
    logic [31:0]   r_utotal [USERS];
    logic [USERS-1:0] r_uvalid;

    // Registered table read data
    logic [31:0]   r_rd_start;
    logic [UW-1:0] r_rd_user;
    logic [31:0]   r_rd_total;
    logic [63:0]   r_rd_name;
    logic          r_rd_ok;

    // Close unit on the current slot
    logic        w_credit;
    logic [30:0] w_el;
    logic [31:0] w_newtot;

    tsta_close u_close (
        .i_stamp    (r_in.stamp),
        .i_start    (r_rd_start),
        .i_max      (r_max),
        .i_total    (r_rd_total),
        .o_credit   (w_credit),
        .o_elapsed  (w_el),
        .o_new_total(w_newtot)
    );

    logic        w_do_credit;
    logic [UW-1:0] w_ui;
    logic [63:0] w_uname_cur;

    assign w_do_credit = r_att[r_slot] && w_credit;
    assign w_ui = r_uidx[UW-1:0];
    assign w_uname_cur = r_uvalid[w_ui] ? r_rd_name : 64'd0;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_beat = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_state  <= S_IDLE;
            r_max    <= MAX_SESSION_RESET;
            r_mark   <= '0;
            r_att    <= '0;
            r_uvalid <= '0;
        end else begin
            r_done <= (r_state == S_FINISH);
            if (i_cfg_we) r_max <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in    <= i_beat;
                        r_nm    <= check_name(i_beat.name_bytes);
                        r_out   <= '0;
                        r_slot  <= '0;
                        r_uidx  <= '0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (r_in.kind) begin
                        r_out.status <= ST_READ;
                        if (32'(r_in.entry_index) < 32'(USERS)) begin
                            r_rd_ok    <= r_uvalid[UW'(r_in.entry_index)];
                            r_rd_name  <= r_uname[UW'(r_in.entry_index)];
                            r_rd_total <= r_utotal[UW'(r_in.entry_index)];
                        end else begin
                            r_rd_ok <= 1'b0;
                        end
                        r_state <= S_RDOUT;
                    end else if (r_in.tty_code == 8'd0) begin
                        r_out.status <= ST_TTYZERO;
                        r_state <= S_FINISH;
                    end else if (r_nm.bad) begin
                        r_out.status <= ST_BADNAME;
                        r_state <= S_FINISH;
                    end else if (r_in.fill_nonzero) begin
                        r_out.status <= ST_IGNORED;
                        r_state <= S_FINISH;
                    end else if (r_in.tty_code == CH_MARK) begin
                        r_mark <= {1'b0, r_in.stamp};
                        r_out.status <= ST_MARK;
                        r_state <= S_FINISH;
                    end else if (r_in.tty_code == CH_SHIFT) begin
                        r_out.status <= ST_SHIFT;
                        r_state <= (r_mark != 32'd0) ? S_SLOT_RD : S_FINISH;
                    end else if (r_in.tty_code == CH_DOWN) begin
                        r_out.status <= ST_DOWN;
                        r_state <= S_SLOT_RD;
                    end else begin
                        r_out.status <= ST_APPLIED;
                        r_slot <= map_slot(r_in.tty_code);
                        r_state <= S_SLOT_RD;
                    end
                end
                S_RDOUT: begin
                    // Unwritten or out-of-range entries read as zero.
                    if (r_rd_ok) begin
                        r_out.entry_name    <= r_rd_name;
                        r_out.entry_seconds <= r_rd_total;
                        r_out.entry_used    <= (r_rd_name != 64'd0);
                    end
                    r_state <= S_FINISH;
                end
                S_SLOT_RD: begin
                    r_rd_start <= r_slot_start[r_slot];
                    r_rd_user  <= r_slot_user[r_slot];
                    r_state    <= (r_out.status == ST_SHIFT) ? S_ACT : S_TOT_RD;
                end
                S_TOT_RD: begin
                    r_rd_total <= r_utotal[r_rd_user];
                    r_state    <= S_ACT;
                end
                S_ACT: begin
                    // Shift or close one slot, then advance the walk, or go on to the name search.
                    if (r_out.status == ST_SHIFT) begin
                        r_slot_start[r_slot] <= r_rd_start + ({1'b0, r_in.stamp} - r_mark);
                    end else begin
                        if (w_do_credit) r_utotal[r_rd_user] <= w_newtot;
                        r_slot_start[r_slot] <= {1'b0, r_in.stamp};
                        r_att[r_slot] <= 1'b0;
                        if (r_out.status == ST_APPLIED && w_do_credit) begin
                            r_out.credited_entry   <= 6'(r_rd_user);
                            r_out.credited_seconds <= w_el;
                        end
                    end
                    if (r_out.status == ST_APPLIED) begin
                        r_state <= (r_nm.name[7:0] == 8'd0) ? S_FINISH : S_SEARCH;
                    end else if (r_slot == 6'(SLOTS - 1)) begin
                        if (r_out.status == ST_SHIFT) r_mark <= '0;
                        r_state <= S_FINISH;
                    end else begin
                        r_slot  <= r_slot + 6'd1;
                        r_state <= S_SLOT_RD;
                    end
                end
                S_SEARCH: begin
                    // Fetch one user entry; stop when the table is exhausted.
                    if (r_uidx >= (UW+1)'(USERS)) begin
                        r_out.status <= ST_FULL;
                        r_state <= S_FINISH;
                    end else begin
                        r_rd_name <= r_uname[w_ui];
                        r_state   <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    // Stop at a free entry or a match.
                    if (w_uname_cur == 64'd0 || w_uname_cur == r_nm.name) begin
                        r_uname[w_ui] <= r_nm.name;
                        if (!r_uvalid[w_ui]) r_utotal[w_ui] <= '0;
                        r_uvalid[w_ui] <= 1'b1;
                        r_slot_user[r_slot] <= w_ui;
                        r_att[r_slot] <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        r_uidx  <= r_uidx + 1'b1;
                        r_state <= S_SEARCH;
                    end
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held two cycles");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("done while busy");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACT |-> r_slot < 6'(SLOTS)) else $error("walk overran");
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_out.credited_seconds < r_max || r_out.credited_seconds == '0)
        else $error("credit over limit");
`endif
endmodule

// File: verif/testbench.sv
module testbench;
    import tsta_pkg::*;

    localparam int NUM_USERS   = 64;
    localparam int RANDOM_BEATS = 1800;
    localparam int SETTLE      = 250;    // longest item is a shutdown
    localparam int STALL_LIMIT = 20000;

    // Ledger of sessions and user totals; predicts each result and checks it.
    class session_ledger;
        bit [5:0]  slot_owner[SLOTS];
        bit        slot_open[SLOTS];
        bit [31:0] slot_since[SLOTS];
        bit [63:0] user_id[NUM_USERS];
        bit [31:0] user_secs[NUM_USERS];
        bit [31:0] mark;
        bit [30:0] limit;
        int        credit_user;
        t_out_beat pending[$];
        int        mismatches;
        int        results;
        int        status_seen[16];

        function new();
            limit = MAX_SESSION_RESET;
        endfunction

        // Close the session on one slot at time t; return the credited seconds.
        function bit [30:0] close_slot(int s, bit [31:0] t);
            longint el;
            longint sum;
            bit [30:0] got;
            got = '0;
            if (slot_open[s]) begin
                el = longint'(t) - longint'($signed(slot_since[s]));
                if (el > 0 && el < longint'(limit)) begin
                    sum = longint'(user_secs[slot_owner[s]]) + el;
                    user_secs[slot_owner[s]] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    got = el[30:0];
                    credit_user = slot_owner[s];
                end
            end
            slot_since[s] = t;
            return got;
        endfunction

        function int slot_of(bit [7:0] c);
            int i;
            if (c[7]) return SLOTS - 1;
            i = c;
            if (c >= "A" && c <= "Z") i += 58;
            if (i >= 97) i -= 39;
            i -= 48;
            if (i < 0 || i >= SLOTS) i = SLOTS - 1;
            return i;
        endfunction

        function void note(t_in_beat b);
            t_out_beat e;
            bit [63:0] who_name;
            bit        ended, bad;
            bit [7:0]  c;
            bit [31:0] t, shift_by;
            int        s, u;
            e = '0;
            who_name = '0;
            ended = 0;
            bad = 0;
            t = {1'b0, b.stamp};
            for (int i = 0; i < 8; i++) begin
                c = b.name_bytes[8*i +: 8];
                if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                    if (ended) bad = 1;
                    else who_name[8*i +: 8] = c;
                end else if (c == 8'h20 || c == 8'h00) begin
                    ended = 1;
                end else begin
                    bad = 1;
                end
            end
            if (b.kind) begin
                e.status = ST_READ;
                e.entry_name = user_id[b.entry_index];
                e.entry_seconds = user_secs[b.entry_index];
                e.entry_used = user_id[b.entry_index] != 0;
            end else if (b.tty_code == 8'h00) begin
                e.status = ST_TTYZERO;
            end else if (bad) begin
                e.status = ST_BADNAME;
            end else if (b.fill_nonzero) begin
                e.status = ST_IGNORED;
            end else if (b.tty_code == CH_MARK) begin
                mark = t;
                e.status = ST_MARK;
            end else if (b.tty_code == CH_SHIFT) begin
                // no mark: nothing moves
                if (mark != 0) begin
                    shift_by = t - mark;
                    foreach (slot_since[k]) slot_since[k] += shift_by;
                    mark = 0;
                end
                e.status = ST_SHIFT;
            end else if (b.tty_code == CH_DOWN) begin
                foreach (slot_open[k]) begin
                    void'(close_slot(k, t));
                    slot_open[k] = 0;
                end
                e.status = ST_DOWN;
            end else begin
                s = slot_of(b.tty_code);
                e.credited_seconds = close_slot(s, t);
                if (e.credited_seconds != 0) e.credited_entry = credit_user[5:0];
                e.status = ST_APPLIED;
                slot_open[s] = 0;
                if (who_name[7:0] != 0) begin
                    for (u = 0; u < NUM_USERS; u++)
                        if (user_id[u] == 0 || user_id[u] == who_name) break;
                    if (u >= NUM_USERS) begin
                        e.status = ST_FULL;     // session left unattached
                    end else begin
                        user_id[u] = who_name;
                        slot_owner[s] = u[5:0];
                        slot_open[s] = 1;
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void check(t_out_beat got);
            t_out_beat e;
            results++;
            status_seen[got.status]++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.status != e.status || got.credited_entry != e.credited_entry ||
                got.credited_seconds != e.credited_seconds || got.entry_name != e.entry_name ||
                got.entry_seconds != e.entry_seconds || got.entry_used != e.entry_used) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d ent=%0d sec=%0d nm=%h tot=%0d u=%0d / got st=%0d ent=%0d sec=%0d nm=%h tot=%0d u=%0d",
                             e.status, e.credited_entry, e.credited_seconds, e.entry_name,
                             e.entry_seconds, e.entry_used, got.status, got.credited_entry,
                             got.credited_seconds, got.entry_name, got.entry_seconds,
                             got.entry_used);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    t_in_beat    i_beat = '0;
    logic        i_cfg_we = 0;
    logic [30:0] i_cfg_data = '0;
    logic        o_done;
    t_out_beat   o_beat;

    session_ledger ledger = new();
    int  accepted = 0;
    int  quiet_cycles = 0;
    bit  calm = 0;                 // no idling in the last stretch
    bit [31:0] clock_now = 1000;
    bit [63:0] regulars[12];

    terminal_session_time_accounting_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_beat(i_beat),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_done(o_done), .o_beat(o_beat)
    );

    always #6 i_clk = ~i_clk;

    // Sample beats and results on the rising edge, run the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                ledger.note(i_beat);
                accepted++;
            end
            if (o_done) ledger.check(o_beat);
            if ((start && !busy) || o_done) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic bit [63:0] make_name(int len);
        bit [63:0] n;
        int        pick;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                pick = $urandom_range(0, 61);
                n[8*i +: 8] = pick < 10 ? 8'("0" + pick) :
                              pick < 36 ? 8'("a" + pick - 10) : 8'("A" + pick - 36);
            end else begin
                n[8*i +: 8] = $urandom_range(0, 1) ? 8'h20 : 8'h00;
            end
        end
        return n;
    endfunction

    // Hold one beat on the inputs until the block takes it.
    task automatic send(t_in_beat b);
        @(negedge i_clk);
        start = 1;
        i_beat = b;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start = 0;
        if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 18)) @(negedge i_clk);
    endtask

    task automatic record(bit [7:0] tty, bit [63:0] nm, bit [31:0] t, bit fill = 0);
        t_in_beat b;
        b = '0;
        b.tty_code = tty;
        b.name_bytes = nm;
        b.stamp = t[30:0];
        b.fill_nonzero = fill;
        b.entry_index = 6'($urandom);
        send(b);
    endtask

    task automatic read_entry(bit [5:0] idx);
        t_in_beat   b;
        bit [127:0] junk;
        junk = {$urandom, $urandom, $urandom, $urandom};
        b = junk[$bits(t_in_beat)-1:0];
        b.kind = 1;
        b.entry_index = idx;
        send(b);
    endtask

    // Drain all expected results, let any walk finish, then write the limit.
    task automatic set_limit(bit [30:0] v);
        while (ledger.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        ledger.limit = v;
    endtask

    task automatic random_beat();
        int        roll;
        bit [7:0]  tty;
        bit [63:0] nm;
        bit [31:0] t;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            read_entry(6'($urandom));
            return;
        end
        clock_now += $urandom_range(0, 3000);
        if ($urandom_range(0, 40) == 0) clock_now = $urandom & 32'h7FFF_FFFF;
        clock_now &= 32'h7FFF_FFFF;
        t = clock_now;
        roll = $urandom_range(0, 99);
        if (roll < 70) tty = $urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9)) :
                              $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) :
                                                     8'("A" + $urandom_range(0, 25));
        else if (roll < 76) tty = CH_MARK;
        else if (roll < 82) tty = CH_SHIFT;
        else if (roll < 85) tty = CH_DOWN;
        else if (roll < 88) tty = 8'h00;
        else tty = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 35) nm = $urandom_range(0, 1) ? 64'h0 : 64'h2020_2020_2020_2020;
        else if (roll < 80) nm = regulars[$urandom_range(0, 11)];
        else if (roll < 93) nm = make_name($urandom_range(1, 8));
        else nm = {$urandom, $urandom};
        record(tty, nm, t, $urandom_range(0, 30) == 0);
    endtask

    initial begin
        foreach (regulars[k]) regulars[k] = make_name($urandom_range(1, 8));
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;

        // Directed opening.
        set_limit(MAX_SESSION_RESET);
        read_entry(0);
        record(8'h00, "bob", 100);
        record("a", 64'h0000_0000_0021_6162, 100);          // bad byte
        record("a", 64'h0000_0000_6300_6162, 100);          // letter after end
        record("a", 64'h0, 100, 1);                         // padding set
        record(CH_SHIFT, 64'h0, 100);                       // shift with no mark
        record("a", 64'h6F6C_7972_6F61_6C41, 200);          // open full-length name
        record("Z", 64'h2020_2020_2079_7A5A, 250);
        record("0", 64'h0000_0000_0000_0031, 300);
        record(8'h80, 64'h0000_0000_0000_0078, 300);
        record(8'hFF, 64'h0, 400);                          // high code, same slot
        record("#", 64'h0000_0000_0000_0071, 400);
        record("{", 64'h0000_0000_0000_0072, 400);
        record(CH_MARK, 64'h0, 500);
        record(CH_SHIFT, 64'h0, 800);                       // move all start times
        record("a", 64'h0, 1500);                           // credit
        record("Z", 64'h0, 250 + 300);                      // zero elapsed after shift
        record("0", 64'h0, 300 + 200000);                   // too long
        record(CH_DOWN, 64'h0, 2000);
        record("a", {$urandom, $urandom} | 64'hFFFF_FFFF_FFFF_FFFF, 2000);
        read_entry(0);
        read_entry(1);
        read_entry(63);

        // Random phases over several limits, extremes included.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_limit(31'd129600);
                1: set_limit(31'd1);
                2: set_limit(31'h7FFF_FFFF);
                3: set_limit(31'($urandom_range(1, 5000)));
                default: set_limit(31'd129600);
            endcase
            if (phase == 4) calm = 1;
            for (int n = 0; n < RANDOM_BEATS / 5; n++) random_beat();
            for (int k = 0; k < NUM_USERS; k += 8) read_entry(k[5:0]);
        end

        while (ledger.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("%0d beats taken, %0d results; applied %0d, full %0d, reads %0d, shifts %0d",
                 accepted, ledger.results, ledger.status_seen[ST_APPLIED],
                 ledger.status_seen[ST_FULL], ledger.status_seen[ST_READ],
                 ledger.status_seen[ST_SHIFT]);
        $display("mismatches: %0d", ledger.mismatches);
        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
